@@ design/sheared_grid_bilinear_interp_defines.svh @@
// assertion macros for the sheared grid interpolator
// no dependencies; included by files that carry concurrent checks
`ifndef SHEARED_GRID_BILINEAR_INTERP_DEFINES_SVH
`define SHEARED_GRID_BILINEAR_INTERP_DEFINES_SVH
`ifndef SYNTH
`define SGBI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SGBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGBI_ASSERT(lbl, clk, rstn, prop, msg)
`define SGBI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/sgbi_pkg.sv @@
// shared types, codes and saturation helper of the sheared grid interpolator
// no dependencies
package sgbi_pkg;

  localparam logic [1:0] FUNC_WR_COL  = 2'd0;
  localparam logic [1:0] FUNC_WR_ROW  = 2'd1;
  localparam logic [1:0] FUNC_WR_NODE = 2'd2;
  localparam logic [1:0] FUNC_QUERY   = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 33;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         col_index;
    logic [5:0]         row_index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] point_x;
    logic signed [31:0] point_z;
  } sgbi_in_t;

  typedef struct packed {
    logic signed [31:0] h_value;
    logic signed [31:0] v_value;
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;
  } sgbi_out_t;

  function automatic logic signed [31:0] sat32_64(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return $signed(v[31:0]);
  endfunction

endpackage

@@ design/sgbi_fmul.sv @@
// shared fixed-point multiplier: registered product, floor shift and saturation
// depends on sgbi_pkg
module sgbi_fmul import sgbi_pkg::*; #(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);

  logic signed [63:0] prod;
  logic signed [63:0] p_r;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    p_r <= prod;
  end

  // arithmetic shift rounds toward minus infinity
  assign q = sat32_64(p_r >>> FRAC);

endmodule

@@ design/sgbi_div.sv @@
// iterative restoring divider: (num << FRAC) / den, truncated, saturated to 32 bits
// depends on sgbi_pkg and the assertion macro header
`include "sheared_grid_bilinear_interp_defines.svh"
module sgbi_div import sgbi_pkg::*; #(
  parameter int FRAC = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [DIV_NUM_W-1:0] num,
  input  logic signed [DIV_DEN_W-1:0] den,
  output logic                        done,
  output logic signed [31:0]          q
);

  localparam int NW   = DIV_NUM_W + FRAC;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [NW-1:0] LIM = NW'(64'h8000_0000);

  logic                 busy_r;
  logic                 done_r;
  logic [CNTW-1:0]      cnt_r;
  logic                 neg_r;
  logic [NW-1:0]        dvd_r;
  logic [NW-1:0]        quot_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] dmag_r;
  logic signed [31:0]   q_r;

  logic [DIV_NUM_W-1:0] num_mag;
  logic [DIV_DEN_W-1:0] den_mag;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;
  logic [NW-1:0]        neg_quot;
  logic signed [31:0]   fin_q;

  assign num_mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
  assign den_mag = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);

  assign trial = {rem_r, dvd_r[NW-1]};
  assign diff  = trial - {1'b0, dmag_r};
  assign ge    = trial >= {1'b0, dmag_r};

  assign neg_quot = NW'(0) - quot_r;

  always_comb begin
    if (neg_r) begin
      fin_q = (quot_r > LIM) ? 32'sh8000_0000 : $signed(neg_quot[31:0]);
    end else begin
      fin_q = (quot_r > LIM - NW'(1)) ? 32'sh7FFF_FFFF : $signed(quot_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == '0) begin
          // zero spacing saturates by the sign of the numerator
          if (num == '0) q_r <= 32'sd0;
          else if (num[DIV_NUM_W-1]) q_r <= 32'sh8000_0000;
          else q_r <= 32'sh7FFF_FFFF;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          neg_r  <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
          dvd_r  <= {num_mag, {FRAC{1'b0}}};
          quot_r <= '0;
          rem_r  <= '0;
          dmag_r <= den_mag;
        end
      end else if (busy_r) begin
        if (cnt_r != CNTW'(NW)) begin
          cnt_r  <= cnt_r + CNTW'(1);
          dvd_r  <= {dvd_r[NW-2:0], 1'b0};
          quot_r <= {quot_r[NW-2:0], ge};
          rem_r  <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end else begin
          q_r    <= fin_q;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

  `SGBI_ASSERT(a_div_no_restart, clk, rst_n, start |-> !busy_r, "divider started while busy")
  `SGBI_ASSERT_ALWAYS(a_div_done_idle, clk, done_r |-> !busy_r, "divider done while busy")

endmodule

@@ design/sheared_grid_bilinear_interp.sv @@
// one request at a time: in_stall stays high while a query runs; the two linear
//   searches and the bit-serial divider take the bulk of a query, and thirteen
//   products run on the single shared multiplier
// reset: synchronous active low; counts return to 2, tables hold no reset value
// top level; depends on sgbi_pkg, sgbi_div, sgbi_fmul and the assertion macro header
`include "sheared_grid_bilinear_interp_defines.svh"
module sheared_grid_bilinear_interp import sgbi_pkg::*; #(
  parameter int MAX_COLUMNS   = 64,
  parameter int MAX_ROWS      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sgbi_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sgbi_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int GD  = MAX_COLUMNS * MAX_ROWS;
  localparam int GAW = $clog2(GD);
  localparam int CB  = $clog2(MAX_COLUMNS + 1);
  localparam int RB  = $clog2(MAX_ROWS + 1);
  localparam int CCW = (CB > CFG_DATA_W) ? CB : CFG_DATA_W;
  localparam int RCW = (RB > CFG_DATA_W) ? RB : CFG_DATA_W;
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRACTION_BITS;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CSTART = 5'd1;
  localparam logic [4:0] S_CSRCH  = 5'd2;
  localparam logic [4:0] S_CRD0   = 5'd3;
  localparam logic [4:0] S_CRD1   = 5'd4;
  localparam logic [4:0] S_CRD2   = 5'd5;
  localparam logic [4:0] S_DIVR   = 5'd6;
  localparam logic [4:0] S_MRB    = 5'd7;
  localparam logic [4:0] S_DZ     = 5'd8;
  localparam logic [4:0] S_RSTART = 5'd9;
  localparam logic [4:0] S_RSRCH  = 5'd10;
  localparam logic [4:0] S_RRD0   = 5'd11;
  localparam logic [4:0] S_RRD1   = 5'd12;
  localparam logic [4:0] S_RRD2   = 5'd13;
  localparam logic [4:0] S_DIVS   = 5'd14;
  localparam logic [4:0] S_WGT    = 5'd15;
  localparam logic [4:0] S_GRD    = 5'd16;
  localparam logic [4:0] S_ACC    = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;

  logic [4:0] state_r, state_nxt;

  // configuration
  logic [CFG_DATA_W-1:0] grid_columns_r;
  logic [CFG_DATA_W-1:0] grid_rows_r;
  logic [CCW-1:0]        nc, ncm2;
  logic [RCW-1:0]        nr, nrm2;

  // tables: {x position, surface height}, row depth, {first, second} node values
  logic [63:0] col_mem  [MAX_COLUMNS];
  logic [31:0] row_mem  [MAX_ROWS];
  logic [63:0] grid_mem [GD];
  logic [63:0] col_rd_r;
  logic [31:0] row_rd_r;
  logic [63:0] grid_rd_r;
  logic [CW-1:0]  col_ra;
  logic [RW-1:0]  row_ra;
  logic [GAW-1:0] grid_ra, grid_wa;
  logic [CW-1:0]  gc;
  logic [RW-1:0]  gr;

  logic in_acc;
  logic col_we, row_we, grid_we;

  // query working registers
  logic signed [31:0] px_r, pz_r;
  logic [CW-1:0]      i_r;
  logic [RW-1:0]      k_r;
  logic signed [31:0] x0_r, h0_r, d0_r;
  logic signed [31:0] bs_r, r_r, s_r, m_r, dz_r;
  logic signed [31:0] w_r [4];
  logic [63:0]        g_r [4];
  logic signed [33:0] acc_h_r, acc_v_r;
  logic [3:0]         st_r;
  logic [3:0]         stm1;
  logic               out_valid_r;
  sgbi_out_t          out_r;
  logic               out_load;

  logic signed [31:0] cur_x, cur_h, cur_d;
  logic               cle, rle;
  logic signed [31:0] rr, ss;

  // divider and multiplier hookup
  logic                        div_start;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic signed [DIV_DEN_W-1:0] div_den;
  logic                        div_done;
  logic signed [31:0]          div_q;
  logic signed [31:0]          mul_a, mul_b, mul_q;

  sgbi_div #(.FRAC(FRACTION_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  sgbi_fmul #(.FRAC(FRACTION_BITS)) u_fmul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  // counts clamped to 2..max at use
  always_comb begin
    if (grid_columns_r < CFG_DATA_W'(2)) nc = CCW'(2);
    else if (CCW'(grid_columns_r) > CCW'(MAX_COLUMNS)) nc = CCW'(MAX_COLUMNS);
    else nc = CCW'(grid_columns_r);
    if (grid_rows_r < CFG_DATA_W'(2)) nr = RCW'(2);
    else if (RCW'(grid_rows_r) > RCW'(MAX_ROWS)) nr = RCW'(MAX_ROWS);
    else nr = RCW'(grid_rows_r);
  end
  assign ncm2 = nc - CCW'(2);
  assign nrm2 = nr - RCW'(2);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == S_IDLE);

  // writes outside the table size are dropped
  assign col_we  = in_acc && (in_data.func == FUNC_WR_COL) &&
                   (32'(in_data.col_index) < MAX_COLUMNS);
  assign row_we  = in_acc && (in_data.func == FUNC_WR_ROW) &&
                   (32'(in_data.row_index) < MAX_ROWS);
  assign grid_we = in_acc && (in_data.func == FUNC_WR_NODE) &&
                   (32'(in_data.col_index) < MAX_COLUMNS) &&
                   (32'(in_data.row_index) < MAX_ROWS);

  assign grid_wa = GAW'(GAW'(in_data.col_index) * GAW'(MAX_ROWS) + GAW'(in_data.row_index));

  // the search addresses the next entry so that its value is ready for the following compare
  always_comb begin
    col_ra = i_r;
    if (state_r == S_CSRCH || state_r == S_CRD1) col_ra = i_r + CW'(1);
    row_ra = k_r;
    if (state_r == S_RSRCH || state_r == S_RRD1) row_ra = k_r + RW'(1);
  end

  // node order: (i,k) (i,k+1) (i+1,k) (i+1,k+1)
  assign gc      = i_r + CW'(st_r[1]);
  assign gr      = k_r + RW'(st_r[0]);
  assign grid_ra = GAW'(GAW'(gc) * GAW'(MAX_ROWS) + GAW'(gr));

  always_ff @(posedge clk) begin
    if (col_we) col_mem[CW'(in_data.col_index)] <= {in_data.value_a, in_data.value_b};
    col_rd_r <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_mem[RW'(in_data.row_index)] <= in_data.value_a;
    row_rd_r <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[grid_wa] <= {in_data.value_a, in_data.value_b};
    grid_rd_r <= grid_mem[grid_ra];
  end

  assign cur_x = $signed(col_rd_r[63:32]);
  assign cur_h = $signed(col_rd_r[31:0]);
  assign cur_d = $signed(row_rd_r);

  // search compares: exact sums, no saturation
  assign cle = cur_x <= px_r;
  assign rle = (33'(cur_d) + 33'(dz_r)) <= 33'(pz_r);

  assign rr   = sat32_64(ONE - 64'(r_r));
  assign ss   = sat32_64(ONE - 64'(s_r));
  assign stm1 = st_r - 4'd1;

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(px_r) - DIV_NUM_W'(x0_r);
    div_den   = DIV_DEN_W'(cur_x) - DIV_DEN_W'(x0_r);
    if (state_r == S_CRD2) div_start = 1'b1;
    if (state_r == S_RRD2) begin
      div_start = 1'b1;
      div_num   = DIV_NUM_W'(pz_r) - (DIV_NUM_W'(d0_r) + DIV_NUM_W'(h0_r)) -
                  DIV_NUM_W'(m_r);
      div_den   = DIV_DEN_W'(cur_d) - DIV_DEN_W'(d0_r);
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = r_r;
    mul_b = bs_r;
    case (state_r)
      S_WGT: begin
        mul_a = st_r[1] ? r_r : rr;
        mul_b = st_r[0] ? s_r : ss;
      end
      S_ACC: begin
        mul_a = w_r[st_r[2:1]];
        mul_b = st_r[0] ? $signed(g_r[st_r[2:1]][31:0]) : $signed(g_r[st_r[2:1]][63:32]);
      end
      default: ;
    endcase
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc && in_data.func == FUNC_QUERY) state_nxt = S_CSTART;
      S_CSTART: state_nxt = S_CSRCH;
      S_CSRCH:  if (!(cle && CCW'(i_r) != ncm2)) state_nxt = S_CRD0;
      S_CRD0:   state_nxt = S_CRD1;
      S_CRD1:   state_nxt = S_CRD2;
      S_CRD2:   state_nxt = S_DIVR;
      S_DIVR:   if (div_done) state_nxt = S_MRB;
      S_MRB:    state_nxt = S_DZ;
      S_DZ:     state_nxt = S_RSTART;
      S_RSTART: state_nxt = S_RSRCH;
      S_RSRCH:  if (!(rle && RCW'(k_r) != nrm2)) state_nxt = S_RRD0;
      S_RRD0:   state_nxt = S_RRD1;
      S_RRD1:   state_nxt = S_RRD2;
      S_RRD2:   state_nxt = S_DIVS;
      S_DIVS:   if (div_done) state_nxt = S_WGT;
      S_WGT:    if (st_r == 4'd4) state_nxt = S_GRD;
      S_GRD:    if (st_r == 4'd4) state_nxt = S_ACC;
      S_ACC:    if (st_r == 4'd8) state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      grid_columns_r <= CFG_DATA_W'(2);
      grid_rows_r    <= CFG_DATA_W'(2);
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_COLUMNS: grid_columns_r <= cfg_data;
          REG_GRID_ROWS:    grid_rows_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        px_r <= in_data.point_x;
        pz_r <= in_data.point_z;
        i_r  <= '0;
      end
      S_CSRCH: begin
        // stop at the first position past x and step back one cell unless at the first, or stop at the last cell
        if (cle && CCW'(i_r) != ncm2) i_r <= i_r + CW'(1);
        else if (!cle && i_r != '0) i_r <= i_r - CW'(1);
      end
      S_CRD1: begin
        x0_r <= cur_x;
        h0_r <= cur_h;
      end
      S_CRD2: bs_r <= sat32_64(64'(cur_h) - 64'(h0_r));
      S_DIVR: if (div_done) r_r <= div_q;
      S_DZ: begin
        m_r  <= mul_q;
        dz_r <= sat32_64(64'(mul_q) + 64'(h0_r));
        k_r  <= '0;
      end
      S_RSRCH: begin
        if (rle && RCW'(k_r) != nrm2) k_r <= k_r + RW'(1);
        else if (!rle && k_r != '0) k_r <= k_r - RW'(1);
      end
      S_RRD1: d0_r <= cur_d;
      S_DIVS: begin
        if (div_done) s_r <= div_q;
        st_r <= 4'd0;
      end
      S_WGT: begin
        if (st_r != 4'd0) w_r[stm1[1:0]] <= mul_q;
        st_r <= (st_r == 4'd4) ? 4'd0 : st_r + 4'd1;
      end
      S_GRD: begin
        if (st_r != 4'd0) g_r[stm1[1:0]] <= grid_rd_r;
        st_r    <= (st_r == 4'd4) ? 4'd0 : st_r + 4'd1;
        acc_h_r <= '0;
        acc_v_r <= '0;
      end
      S_ACC: begin
        // even steps feed the first grid, odd steps the second
        if (st_r != 4'd0) begin
          if (stm1[0]) acc_v_r <= acc_v_r + 34'(mul_q);
          else acc_h_r <= acc_h_r + 34'(mul_q);
        end
        st_r <= st_r + 4'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_r.h_value  <= sat32_64(64'(acc_h_r));
      out_r.v_value  <= sat32_64(64'(acc_v_r));
      out_r.cell_col <= 6'(i_r);
      out_r.cell_row <= 6'(k_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SGBI_ASSERT(a_div_done_state, clk, rst_n, div_done |-> (state_r == S_DIVR || state_r == S_DIVS), "divider result outside a wait state")
  `SGBI_ASSERT(a_col_search_bound, clk, rst_n, (state_r == S_CSRCH) |-> (CCW'(i_r) <= ncm2), "column search past last cell")
  `SGBI_ASSERT(a_row_search_bound, clk, rst_n, (state_r == S_RSRCH) |-> (RCW'(k_r) <= nrm2), "row search past last cell")
  `SGBI_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_DONE), "result raised without a finished query")

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the sheared grid bilinear interpolator
// depends on sgbi_pkg and the sheared_grid_bilinear_interp top level
module tb_top;
  import sgbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOL = 64;
  localparam int NROW = 64;
  localparam int FB = 16;
  localparam longint UNIT = 64'sd1 << FB;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 400;
  localparam int BLK = 12;
  localparam int SEG_ITEMS = 100;

  // expected-result tracker with its own copy of the tables and counts
  class interp_scoreboard;
    int col_pos[NCOL];
    int surf_h[NCOL];
    int row_dep[NROW];
    int grid_a[NCOL][NROW];
    int grid_b[NCOL][NROW];
    int n_cols = 2;
    int n_rows = 2;
    int errors = 0;
    sgbi_out_t pending_q[$];

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return sat(p >>> FB);
    endfunction

    function longint qdiv(longint num, longint den);
      if (den == 0) begin
        if (num > 0) return 64'sd2147483647;
        if (num < 0) return -64'sd2147483648;
        return 0;
      end
      return sat((num * UNIT) / den);
    endfunction

    function int clamp_count(int v);
      if (v < 2) return 2;
      if (v > 64) return 64;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_GRID_COLUMNS) n_cols = val;
      else n_rows = val;
    endfunction

    function longint blend(int g[NCOL][NROW], int i, int k,
                           longint w00, longint w01, longint w10, longint w11);
      return sat(qmul(w00, g[i][k]) + qmul(w01, g[i][k+1]) +
                 qmul(w11, g[i+1][k+1]) + qmul(w10, g[i+1][k]));
    endfunction

    function sgbi_out_t interpolate(sgbi_in_t q);
      int nc, nr, i, k;
      longint px, pz, r, s, slope, dz, rr, ss, w00, w01, w10, w11;
      sgbi_out_t o;
      nc = clamp_count(n_cols);
      nr = clamp_count(n_rows);
      px = q.point_x;
      pz = q.point_z;
      i = 0;
      k = 0;
      // column search clamped to first and last cell
      if (col_pos[0] <= px) begin
        i = 1;
        while (i < nc - 1 && col_pos[i] <= px) i++;
        i--;
      end
      r = qdiv(px - col_pos[i], longint'(col_pos[i+1]) - col_pos[i]);
      slope = sat(longint'(surf_h[i+1]) - surf_h[i]);
      dz = sat(qmul(r, slope) + surf_h[i]);
      // row search on depths shifted by the surface
      if (longint'(row_dep[0]) + dz <= pz) begin
        k = 1;
        while (k < nr - 1 && longint'(row_dep[k]) + dz <= pz) k++;
        k--;
      end
      s = qdiv(pz - (longint'(row_dep[k]) + surf_h[i]) - qmul(slope, r),
               longint'(row_dep[k+1]) - row_dep[k]);
      rr = sat(UNIT - r);
      ss = sat(UNIT - s);
      w00 = qmul(rr, ss);
      w01 = qmul(rr, s);
      w11 = qmul(r, s);
      w10 = qmul(r, ss);
      o.h_value = 32'(blend(grid_a, i, k, w00, w01, w10, w11));
      o.v_value = 32'(blend(grid_b, i, k, w00, w01, w10, w11));
      o.cell_col = i[5:0];
      o.cell_row = k[5:0];
      return o;
    endfunction

    function void note_request(sgbi_in_t q);
      case (q.func)
        FUNC_WR_COL: begin
          col_pos[q.col_index] = q.value_a;
          surf_h[q.col_index] = q.value_b;
        end
        FUNC_WR_ROW: row_dep[q.row_index] = q.value_a;
        FUNC_WR_NODE: begin
          grid_a[q.col_index][q.row_index] = q.value_a;
          grid_b[q.col_index][q.row_index] = q.value_b;
        end
        default: pending_q.push_back(interpolate(q));
      endcase
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(sgbi_out_t got);
      sgbi_out_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result, h_value", got.h_value, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.h_value !== want.h_value) report("h_value", got.h_value, want.h_value);
      if (got.v_value !== want.v_value) report("v_value", got.v_value, want.v_value);
      if (got.cell_col !== want.cell_col) report("cell_col", got.cell_col, want.cell_col);
      if (got.cell_row !== want.cell_row) report("cell_row", got.cell_row, want.cell_row);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sgbi_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sgbi_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  interp_scoreboard sb = new();
  int gap_pct = 0;      // chance the sender idles before a request
  int stall_pct = 0;    // chance the receiver stalls in a cycle
  int hold_len = 0;     // long receiver hold-off, consumed by the stall process
  int cycles = 0;

  sheared_grid_bilinear_interp DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // one request: optional idle gap, then hold valid until accepted
  task send(sgbi_in_t item);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    sb.note_request(item);
  endtask

  task send_fields(logic [1:0] f, int c, int r, int a, int b, int x, int z);
    sgbi_in_t item;
    item.func = f;
    item.col_index = c[5:0];
    item.row_index = r[5:0];
    item.value_a = a;
    item.value_b = b;
    item.point_x = x;
    item.point_z = z;
    send(item);
  endtask

  // wait for all results, then let any trailing write finish
  task drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ascending column positions and row depths with random spacing
  task build_axes();
    int base, step;
    base = $urandom_range(2 * 1048576) - 1048576;
    for (int c = 0; c < NCOL; c++) begin
      step = $urandom_range(262144, 1);
      send_fields(FUNC_WR_COL, c, $urandom, base, $urandom_range(2097152) - 1048576,
                  $urandom, $urandom);
      base += step;
    end
    base = $urandom_range(2 * 1048576) - 1048576;
    for (int r = 0; r < NROW; r++) begin
      step = $urandom_range(262144, 1);
      send_fields(FUNC_WR_ROW, $urandom, r, base, $urandom, $urandom, $urandom);
      base += step;
    end
  endtask

  function int node_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(1 << 22) - (1 << 21);
  endfunction

  function int clip32(longint v);
    return 32'(sb.sat(v));
  endfunction

  // query near the grid, off the grid, or anywhere
  task random_query();
    int c, r, nc, nr;
    longint x, z;
    nc = sb.clamp_count(sb.n_cols);
    nr = sb.clamp_count(sb.n_rows);
    c = $urandom_range(nc - 1);
    r = $urandom_range(nr - 1);
    x = longint'(sb.col_pos[c]) + $signed($urandom_range(524288)) - 262144;
    z = longint'(sb.row_dep[r]) + sb.surf_h[c] + $signed($urandom_range(524288)) - 262144;
    if ($urandom_range(9) == 0) x = $signed($urandom);
    if ($urandom_range(9) == 0) z = $signed($urandom);
    send_fields(FUNC_QUERY, $urandom, $urandom, $urandom, $urandom, clip32(x), clip32(z));
  endtask

  task random_item();
    int pick, c, r, nc;
    pick = $urandom_range(99);
    nc = sb.clamp_count(sb.n_cols);
    c = $urandom_range(63);
    r = $urandom_range(63);
    if (pick < 55) begin
      random_query();
    end else if (pick < 72) begin
      send_fields(FUNC_WR_NODE, c, r, node_value(), node_value(), $urandom, $urandom);
    end else if (pick < 86) begin
      // mostly a nudge of an existing column, sometimes noise or a duplicate
      c = $urandom_range(nc - 1);
      if ($urandom_range(4) == 0)
        send_fields(FUNC_WR_COL, c, r, $urandom, $urandom, $urandom, $urandom);
      else if ($urandom_range(4) == 0 && c > 0)
        send_fields(FUNC_WR_COL, c, r, sb.col_pos[c-1], sb.surf_h[c], $urandom, $urandom);
      else
        send_fields(FUNC_WR_COL, c, r, sb.col_pos[c] + $urandom_range(4096) - 2048,
                    $urandom_range(2097152) - 1048576, $urandom, $urandom);
    end else begin
      r = $urandom_range(sb.clamp_count(sb.n_rows) - 1);
      if ($urandom_range(4) == 0)
        send_fields(FUNC_WR_ROW, c, r, $urandom, $urandom, $urandom, $urandom);
      else if ($urandom_range(4) == 0 && r > 0)
        send_fields(FUNC_WR_ROW, c, r, sb.row_dep[r-1], $urandom, $urandom, $urandom);
      else
        send_fields(FUNC_WR_ROW, c, r, sb.row_dep[r] + $urandom_range(4096) - 2048,
                    $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    // grid sizes stay inside the written nodes: two wide strips and a small block
    int col_cfg[8] = '{2, 64, 0, 127, 12, 5, 1, 0};
    int row_cfg[8] = '{2, 2, 127, 1, 5, 12, 64, 0};
    int gaps[4] = '{0, 71, 0, 21};
    int stalls[4] = '{0, 0, 71, 21};
    int seg;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every node that a query can reach gets written before any query reads it
    build_axes();
    for (int c = 0; c < NCOL; c++)
      for (int r = 0; r < NROW; r++)
        if (c < 2 || r < 2 || (c < BLK && r < BLK))
          send_fields(FUNC_WR_NODE, c, r, node_value(), node_value(), $urandom, $urandom);

    // directed: extreme points on the smallest grid
    drain();
    write_reg(REG_GRID_COLUMNS, 2);
    write_reg(REG_GRID_ROWS, 2);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000);
    send_fields(FUNC_QUERY, 63, 63, -1, -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, sb.col_pos[0], sb.row_dep[0] + sb.surf_h[0]);
    // extreme node values saturate the blend
    send_fields(FUNC_WR_NODE, 1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
    send_fields(FUNC_WR_NODE, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, sb.col_pos[1], sb.row_dep[1] + sb.surf_h[1]);
    // zero spacing in both directions
    send_fields(FUNC_WR_COL, 1, 0, sb.col_pos[0], 32'sh7FFF_FFFF, 0, 0);
    send_fields(FUNC_WR_ROW, 0, 1, sb.row_dep[0], 0, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, sb.col_pos[0] + 100, sb.row_dep[0] - 100);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, sb.col_pos[0] - 100, 32'sh7FFF_FFFF);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, sb.col_pos[0], 32'sh8000_0000);
    // extreme table entries
    send_fields(FUNC_WR_COL, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
    send_fields(FUNC_WR_COL, 1, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0);
    send_fields(FUNC_WR_ROW, 0, 0, 32'sh8000_0000, 0, 0, 0);
    send_fields(FUNC_WR_ROW, 0, 1, 32'sh7FFF_FFFF, 0, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, 0, 0);
    send_fields(FUNC_QUERY, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_fields(FUNC_QUERY, 63, 63, -1, -1, 32'sh8000_0000, 32'sh7FFF_FFFF);

    // random segments over idling modes and grid sizes
    for (seg = 0; seg < 8; seg++) begin
      drain();
      gap_pct = gaps[seg % 4];
      stall_pct = stalls[seg % 4];
      write_reg(REG_GRID_COLUMNS,
                CFG_DATA_W'((seg == 7) ? $urandom_range(BLK) : col_cfg[seg]));
      write_reg(REG_GRID_ROWS,
                CFG_DATA_W'((seg == 7) ? $urandom_range(BLK) : row_cfg[seg]));
      if (seg % 4 == 0) build_axes();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // long receiver hold-off while requests keep coming
        if (seg == 1 && n == 20) hold_len = 600;
        random_item();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
